@@ rtl/clp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the clipped line pixel generator.
// No dependencies; every other file refers to this package by scoped names.
package clp_pkg;

    localparam int COORD_W = 16;
    localparam int FRAME_W = 13;
    localparam int ADDR_W  = 24;
    localparam int COLOR_W = 32;
    localparam int DELTA_W = COORD_W + 2;
    localparam int ERR_W   = COORD_W + 3;
    localparam int E2_W    = COORD_W + 4;
    localparam int CMP_W   = ((COORD_W > FRAME_W) ? COORD_W : FRAME_W) + 1;
    localparam int PROD_W  = 2 * FRAME_W;

    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RESET  = FRAME_W'(640);
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RESET = FRAME_W'(480);

    // operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic                      op;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0]        line_color;
    } item_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] pixel_value;
        logic               write_enable;
        logic               last;
    } pixel_word_t;

    typedef struct packed {
        logic [FRAME_W-1:0] width;
        logic [FRAME_W-1:0] height;
    } frame_cfg_t;

    typedef struct packed {
        logic active;
        logic emit;
    } line_status_t;

endpackage

@@ rtl/clp_cfg_regs.sv @@
`timescale 1ns / 1ps
// Frame size registers written through the configuration port.
// Depends on clp_pkg.
module clp_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [clp_pkg::FRAME_W-1:0] cfg_data,
    output clp_pkg::frame_cfg_t         frame
);

    logic [clp_pkg::FRAME_W-1:0] width_reg;
    logic [clp_pkg::FRAME_W-1:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= clp_pkg::FRAME_WIDTH_RESET;
            height_reg <= clp_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                clp_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                clp_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign frame.width  = width_reg;
    assign frame.height = height_reg;

endmodule

@@ rtl/clp_frame_test.sv @@
`timescale 1ns / 1ps
// Exclusive bounds test of a signed point against the frame size.
// Depends on clp_pkg.
module clp_frame_test (
    input  logic signed [clp_pkg::COORD_W-1:0] x,
    input  logic signed [clp_pkg::COORD_W-1:0] y,
    input  clp_pkg::frame_cfg_t                frame,
    output logic                               in_bounds
);

    logic [clp_pkg::CMP_W-1:0] x_ext;
    logic [clp_pkg::CMP_W-1:0] y_ext;

    assign x_ext = clp_pkg::CMP_W'($unsigned(x));
    assign y_ext = clp_pkg::CMP_W'($unsigned(y));

    assign in_bounds = !x[clp_pkg::COORD_W-1] && !y[clp_pkg::COORD_W-1]
                    && (x_ext < clp_pkg::CMP_W'(frame.width))
                    && (y_ext < clp_pkg::CMP_W'(frame.height));

endmodule

@@ rtl/clp_line_state.sv @@
`timescale 1ns / 1ps
// Line state registers and the combinational Bresenham step / line load logic.
// Depends on clp_pkg and clp_frame_test.
module clp_line_state (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  clp_pkg::item_word_t    item,
    input  clp_pkg::frame_cfg_t    frame,
    output clp_pkg::pixel_word_t   result,
    output clp_pkg::line_status_t  status
);

    localparam int CW = clp_pkg::COORD_W;
    localparam int DW = clp_pkg::DELTA_W;
    localparam int EW = clp_pkg::ERR_W;
    localparam int E2W = clp_pkg::E2_W;

    logic signed [CW-1:0]  cur_x_reg, cur_x_next;
    logic signed [CW-1:0]  cur_y_reg, cur_y_next;
    logic signed [CW-1:0]  target_x_reg, target_x_next;
    logic signed [CW-1:0]  target_y_reg, target_y_next;
    logic signed [DW-1:0]  delta_x_reg, delta_x_next;
    logic signed [DW-1:0]  delta_y_neg_reg, delta_y_neg_next;
    logic signed [EW-1:0]  error_term_reg, error_term_next;
    logic                  step_x_neg_reg, step_x_neg_next;
    logic                  step_y_neg_reg, step_y_neg_next;
    logic [clp_pkg::COLOR_W-1:0] held_color_reg, held_color_next;
    logic                  line_active_reg, line_active_next;

    logic                  start_inside;
    logic                  cur_inside;
    logic                  at_end;
    logic signed [DW-1:0]  sx_ext, sy_ext, ex_ext, ey_ext;
    logic signed [DW-1:0]  dx_start, dyn_start;
    logic signed [E2W-1:0] e2;
    logic                  move_x, move_y;
    logic signed [E2W-1:0] err_sum;
    logic [clp_pkg::CMP_W-1:0]  x_ext, y_ext;
    logic [clp_pkg::PROD_W-1:0] row_base;
    logic [clp_pkg::PROD_W-1:0] lin_addr;

    clp_frame_test u_start_test (
        .x         (item.start_x),
        .y         (item.start_y),
        .frame     (frame),
        .in_bounds (start_inside)
    );

    clp_frame_test u_cur_test (
        .x         (cur_x_reg),
        .y         (cur_y_reg),
        .frame     (frame),
        .in_bounds (cur_inside)
    );

    // line load terms
    assign sx_ext    = DW'(item.start_x);
    assign sy_ext    = DW'(item.start_y);
    assign ex_ext    = DW'(item.end_x);
    assign ey_ext    = DW'(item.end_y);
    assign dx_start  = (ex_ext > sx_ext) ? (ex_ext - sx_ext) : (sx_ext - ex_ext);
    assign dyn_start = (ey_ext > sy_ext) ? (sy_ext - ey_ext) : (ey_ext - sy_ext);

    // step terms
    assign at_end  = (cur_x_reg == target_x_reg) && (cur_y_reg == target_y_reg);
    assign e2      = E2W'(error_term_reg) <<< 1;
    assign move_x  = (e2 >= E2W'(delta_y_neg_reg));
    assign move_y  = (e2 <= E2W'(delta_x_reg));
    assign err_sum = E2W'(error_term_reg)
                   + (move_x ? E2W'(delta_y_neg_reg) : E2W'(0))
                   + (move_y ? E2W'(delta_x_reg) : E2W'(0));

    // address of the current pixel; only in-frame pixels carry one
    assign x_ext    = clp_pkg::CMP_W'($unsigned(cur_x_reg));
    assign y_ext    = clp_pkg::CMP_W'($unsigned(cur_y_reg));
    assign row_base = clp_pkg::PROD_W'(y_ext[clp_pkg::FRAME_W-1:0])
                    * clp_pkg::PROD_W'(frame.width);
    assign lin_addr = row_base + clp_pkg::PROD_W'(x_ext[clp_pkg::FRAME_W-1:0]);

    always_comb
    begin
        result.pixel_address = cur_inside ? lin_addr[clp_pkg::ADDR_W-1:0]
                                          : '0;
        result.pixel_value   = held_color_reg;
        result.write_enable  = cur_inside;
        result.last          = at_end;
    end

    assign status.active = line_active_reg;
    assign status.emit   = (item.op == clp_pkg::OP_STEP) && line_active_reg;

    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        target_x_next    = target_x_reg;
        target_y_next    = target_y_reg;
        delta_x_next     = delta_x_reg;
        delta_y_neg_next = delta_y_neg_reg;
        error_term_next  = error_term_reg;
        step_x_neg_next  = step_x_neg_reg;
        step_y_neg_next  = step_y_neg_reg;
        held_color_next  = held_color_reg;
        line_active_next = line_active_reg;
        if (advance)
        begin
            case (item.op)
                clp_pkg::OP_START:
                begin
                    if (!start_inside)
                    begin
                        line_active_next = 1'b0;
                    end
                    else
                    begin
                        cur_x_next       = item.start_x;
                        cur_y_next       = item.start_y;
                        target_x_next    = item.end_x;
                        target_y_next    = item.end_y;
                        delta_x_next     = dx_start;
                        delta_y_neg_next = dyn_start;
                        step_x_neg_next  = !(item.start_x < item.end_x);
                        step_y_neg_next  = !(item.start_y < item.end_y);
                        error_term_next  = EW'(dx_start) + EW'(dyn_start);
                        held_color_next  = item.line_color;
                        line_active_next = 1'b1;
                    end
                end
                clp_pkg::OP_STEP:
                begin
                    if (line_active_reg)
                    begin
                        if (at_end)
                        begin
                            line_active_next = 1'b0;
                        end
                        else
                        begin
                            error_term_next = EW'(err_sum);
                            if (move_x)
                                cur_x_next = step_x_neg_reg ? cur_x_reg - CW'(1)
                                                            : cur_x_reg + CW'(1);
                            if (move_y)
                                cur_y_next = step_y_neg_reg ? cur_y_reg - CW'(1)
                                                            : cur_y_reg + CW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            delta_x_reg     <= '0;
            delta_y_neg_reg <= '0;
            error_term_reg  <= '0;
            step_x_neg_reg  <= 1'b0;
            step_y_neg_reg  <= 1'b0;
            held_color_reg  <= '0;
            line_active_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            target_x_reg    <= target_x_next;
            target_y_reg    <= target_y_next;
            delta_x_reg     <= delta_x_next;
            delta_y_neg_reg <= delta_y_neg_next;
            error_term_reg  <= error_term_next;
            step_x_neg_reg  <= step_x_neg_next;
            step_y_neg_reg  <= step_y_neg_next;
            held_color_reg  <= held_color_next;
            line_active_reg <= line_active_next;
        end
    end

endmodule

@@ rtl/clipped_line_pixel_generator_core.sv @@
`timescale 1ns / 1ps
// Clipped Bresenham line pixel generator, top level.
// Path: a step word is held in the input register, then retired into the result
//   register and presented on pixel. Throughput: one word per cycle while pixel_stall
//   is low, set by the combinational error update and the 13x13 address multiply.
// Reset: frame 640 x 480, no line active, input and result registers empty.
// Depends on clp_pkg, clp_cfg_regs, clp_frame_test and clp_line_state.
module clipped_line_pixel_generator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // item channel
    input  logic                        item_valid,
    output logic                        item_stall,
    input  clp_pkg::item_word_t         item,
    // pixel channel
    output logic                        pixel_valid,
    input  logic                        pixel_stall,
    output clp_pkg::pixel_word_t        pixel,
    // configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [clp_pkg::FRAME_W-1:0] cfg_data
);

    clp_pkg::frame_cfg_t   frame;
    clp_pkg::pixel_word_t  step_result;
    clp_pkg::line_status_t line_status;

    logic                  hold_valid_reg, hold_valid_next;
    clp_pkg::item_word_t   hold_word_reg;
    logic                  out_valid_reg, out_valid_next;
    clp_pkg::pixel_word_t  out_word_reg;

    logic                  accept;
    logic                  out_free;
    logic                  advance;

    clp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame     (frame)
    );

    // The held item is retired into the line state when the result slot can
    // take a word; this also applies the item's state change in that cycle.
    clp_line_state u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (hold_word_reg),
        .frame   (frame),
        .result  (step_result),
        .status  (line_status)
    );

    // Result slot is free when empty or being drained this cycle.
    assign out_free   = !out_valid_reg || !pixel_stall;
    assign advance    = hold_valid_reg && out_free;
    // Stall input only while the held word cannot move on.
    assign item_stall = hold_valid_reg && !out_free;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
            hold_valid_next = 1'b1;
        else if (advance)
            hold_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = advance && line_status.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: load on handshake, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
            hold_word_reg <= item;
        if (advance && line_status.emit)
            out_word_reg <= step_result;
    end

    assign pixel_valid = out_valid_reg;
    assign pixel       = out_word_reg;

    // A new pixel word only appears after a held step word was retired.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && line_status.emit))
        else $error("pixel word appeared without a retired step word");

    // Retiring the end point pixel closes the line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && line_status.emit && step_result.last) |=> !line_status.active)
        else $error("line still active after its end point");

    // Off-frame pixels carry a zero address.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> (pixel.write_enable || (pixel.pixel_address == '0)))
        else $error("off-frame pixel with nonzero address");

endmodule
